FILE: src/clm_pkg.sv
// Shared types and constants of the caching lock table manager.
package clm_pkg;

	localparam int LOCK_W    = 6;
	localparam int CLIENT_W  = 4;
	localparam int REQ_ID_W  = 32;
	localparam int NUM_LOCKS = 1 << LOCK_W;
	localparam int NUM_CLIENTS = 1 << CLIENT_W;
	localparam int REC_AW    = LOCK_W + CLIENT_W;
	localparam int NUM_RECS  = 1 << REC_AW;

	localparam logic CMD_ACQUIRE = 1'b0;
	localparam logic CMD_RELEASE = 1'b1;

	localparam logic [1:0] PH_FREE     = 2'd0;
	localparam logic [1:0] PH_LOCKED   = 2'd1;
	localparam logic [1:0] PH_WAIT     = 2'd2;
	localparam logic [1:0] PH_RETRYING = 2'd3;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_RETRY = 2'd1;
	localparam logic [1:0] ST_IOERR = 2'd2;
	localparam logic [1:0] ST_NOENT = 2'd3;

	localparam logic [1:0] NK_NONE   = 2'd0;
	localparam logic [1:0] NK_REVOKE = 2'd1;
	localparam logic [1:0] NK_RETRY  = 2'd2;

	typedef struct packed {
		logic                command;
		logic [LOCK_W-1:0]   lock_index;
		logic [CLIENT_W-1:0] client;
		logic [REQ_ID_W-1:0] request_id;
	} req_t;

	typedef struct packed {
		logic [1:0]          status;
		logic [1:0]          notice_kind;
		logic [CLIENT_W-1:0] notice_client;
		logic [LOCK_W-1:0]   notice_lock;
		logic [REQ_ID_W-1:0] notice_request_id;
	} rsp_t;

	typedef struct packed {
		logic                exists;
		logic [1:0]          phase;
		logic [CLIENT_W-1:0] owner;
		logic [NUM_CLIENTS-1:0] waiters;
	} lock_ent_t;

	typedef struct packed {
		logic [REQ_ID_W-1:0] req_id;
		logic [1:0]          status;
		logic                revoke;
	} rec_t;

	typedef struct packed {
		logic              rd_en;
		logic [REC_AW-1:0] rd_addr;
		logic              wr_en;
		logic [REC_AW-1:0] wr_addr;
		rec_t              wr_data;
	} rec_port_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_NREQ,
		S_NDATA,
		S_FIN
	} state_t;

endpackage

FILE: src/clm_lock_mem.sv
// Lock table memory with per-entry valid bits cleared at reset.
module clm_lock_mem (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        rd_en,
	input  logic [clm_pkg::LOCK_W-1:0]  rd_addr,
	output clm_pkg::lock_ent_t          rd_data,
	input  logic                        wr_en,
	input  logic [clm_pkg::LOCK_W-1:0]  wr_addr,
	input  clm_pkg::lock_ent_t          wr_data
);

	clm_pkg::lock_ent_t                  mem [clm_pkg::NUM_LOCKS];
	logic [clm_pkg::NUM_LOCKS-1:0]       vld_q;
	clm_pkg::lock_ent_t                  rd_q;
	logic                                rd_vld_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= vld_q[rd_addr];
			end
		end
	end

	// never-written entries read as a free, missing lock
	assign rd_data = rd_vld_q ? rd_q : '0;

endmodule

FILE: src/clm_rec_mem.sv
// Per lock and client request record memory with a clearing sweep after reset.
module clm_rec_mem (
	input  logic               clk,
	input  logic               arst_n,
	input  clm_pkg::rec_port_t port,
	output clm_pkg::rec_t      rd_data,
	output logic               busy
);

	clm_pkg::rec_t             mem [clm_pkg::NUM_RECS];
	logic [clm_pkg::REC_AW:0]  clr_cnt_q;
	logic                      we;
	logic [clm_pkg::REC_AW-1:0] wa;
	clm_pkg::rec_t             wd;

	assign busy = !clr_cnt_q[clm_pkg::REC_AW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (busy) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
		end
	end

	always_comb begin
		we = port.wr_en;
		wa = port.wr_addr;
		wd = port.wr_data;
		if (busy) begin
			we = 1'b1;
			wa = clr_cnt_q[clm_pkg::REC_AW-1:0];
			wd = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		if (port.rd_en) begin
			rd_data <= mem[port.rd_addr];
		end
	end

endmodule

FILE: src/caching_lock_table_manager_top.sv
// Caching lock table manager: request sequencer around the lock and record memories.
// An accepted item passes the execute and finish states, or with a notice the execute,
// notice request and notice data states, before its result is loaded; the next item is
// taken after that load, which waits while the result is stalled. The record memory port
// is used twice when a notice needs the notified client's request id. Reset: lock valid
// bits clear at once; no item is taken during the record sweep. is_primary resets to 1.
module caching_lock_table_manager_top (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  clm_pkg::req_t  req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output clm_pkg::rsp_t  rsp,
	input  logic           cfg_we,
	input  logic           cfg_wdata
);

	clm_pkg::state_t    state_q, state_n;
	clm_pkg::req_t      item_q;
	logic [1:0]         st_q;
	logic [1:0]         kind_q;
	logic [clm_pkg::CLIENT_W-1:0] who_q;
	logic               is_prim_q;
	logic               out_vld_q;
	clm_pkg::rsp_t      out_q;

	clm_pkg::lock_ent_t le, ent_n;
	clm_pkg::rec_t      rc, rec_rd;
	clm_pkg::rec_port_t rp;
	logic               rec_busy;
	logic               lk_wr;
	logic               accept;
	logic               out_free;
	logic               load_out;
	logic [1:0]         st_c, kind_c;
	logic [clm_pkg::CLIENT_W-1:0] who_c;
	logic               rec_wr;
	clm_pkg::rec_t      rec_n;
	logic [clm_pkg::NUM_CLIENTS-1:0] bit_c;
	logic               lowest_found;

	assign accept   = req_valid && !req_stall;
	assign out_free = !out_vld_q || !rsp_stall;
	assign req_stall = rec_busy || (state_q != clm_pkg::S_IDLE);

	clm_lock_mem u_lock (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_addr (req.lock_index),
		.rd_data (le),
		.wr_en   (lk_wr),
		.wr_addr (item_q.lock_index),
		.wr_data (ent_n)
	);

	clm_rec_mem u_rec (
		.clk     (clk),
		.arst_n  (arst_n),
		.port    (rp),
		.rd_data (rec_rd),
		.busy    (rec_busy)
	);

	assign rc = rec_rd;

	// request processing on the lock entry and the requester's record
	always_comb begin
		bit_c  = '0;
		bit_c[item_q.client] = 1'b1;
		ent_n  = le;
		st_c   = clm_pkg::ST_OK;
		kind_c = clm_pkg::NK_NONE;
		who_c  = '0;
		lk_wr  = 1'b0;
		rec_wr = 1'b0;
		rec_n  = rc;
		lowest_found = 1'b0;
		if (item_q.command == clm_pkg::CMD_ACQUIRE) begin
			lk_wr = 1'b1;
			if (!le.exists) begin
				ent_n = '0;
				ent_n.exists = 1'b1;
			end
			if (rc.req_id == item_q.request_id) begin
				st_c = rc.status;
				if (rc.revoke && (ent_n.phase == clm_pkg::PH_LOCKED ||
				                  ent_n.phase == clm_pkg::PH_WAIT)) begin
					kind_c = clm_pkg::NK_REVOKE;
				end
			end else if (rc.req_id > item_q.request_id) begin
				st_c = clm_pkg::ST_IOERR;
			end else begin
				rec_n.revoke = 1'b0;
				case (ent_n.phase)
					clm_pkg::PH_FREE: begin
						ent_n.phase = clm_pkg::PH_LOCKED;
						ent_n.owner = item_q.client;
					end
					clm_pkg::PH_LOCKED: begin
						ent_n.phase   = clm_pkg::PH_WAIT;
						ent_n.waiters = ent_n.waiters | bit_c;
						rec_n.revoke  = 1'b1;
						st_c          = clm_pkg::ST_RETRY;
					end
					clm_pkg::PH_WAIT: begin
						ent_n.waiters = ent_n.waiters | bit_c;
						st_c          = clm_pkg::ST_RETRY;
					end
					default: begin
						if ((ent_n.waiters & bit_c) != '0) begin
							ent_n.waiters = ent_n.waiters & ~bit_c;
							ent_n.owner   = item_q.client;
							if (ent_n.waiters != '0) begin
								ent_n.phase  = clm_pkg::PH_WAIT;
								rec_n.revoke = 1'b1;
							end else begin
								ent_n.phase = clm_pkg::PH_LOCKED;
							end
						end else begin
							ent_n.waiters = ent_n.waiters | bit_c;
							st_c          = clm_pkg::ST_RETRY;
						end
					end
				endcase
				rec_wr       = 1'b1;
				rec_n.req_id = item_q.request_id;
				rec_n.status = st_c;
				if (rec_n.revoke) begin
					kind_c = clm_pkg::NK_REVOKE;
				end
			end
			who_c = ent_n.owner;
		end else begin
			if (!le.exists) begin
				st_c = clm_pkg::ST_NOENT;
			end else if (rc.req_id == '0) begin
				st_c = rc.status;
			end else if (le.phase == clm_pkg::PH_LOCKED || le.phase == clm_pkg::PH_WAIT) begin
				if (le.owner != item_q.client || rc.req_id != item_q.request_id) begin
					st_c = clm_pkg::ST_IOERR;
				end else begin
					lk_wr = 1'b1;
					if (le.phase == clm_pkg::PH_WAIT) begin
						ent_n.phase = clm_pkg::PH_RETRYING;
						// pick the lowest-numbered waiter
						for (int i = 0; i < clm_pkg::NUM_CLIENTS; i++) begin
							if (le.waiters[i] && !lowest_found) begin
								lowest_found = 1'b1;
								who_c  = clm_pkg::CLIENT_W'(i);
								kind_c = clm_pkg::NK_RETRY;
							end
						end
					end else begin
						ent_n.phase = clm_pkg::PH_FREE;
					end
					ent_n.owner  = '0;
					rec_wr       = 1'b1;
					rec_n.req_id = '0;
					rec_n.status = clm_pkg::ST_OK;
					rec_n.revoke = 1'b0;
				end
			end else begin
				st_c         = clm_pkg::ST_IOERR;
				rec_wr       = 1'b1;
				rec_n.status = clm_pkg::ST_IOERR;
				rec_n.revoke = 1'b0;
			end
		end
		if (!is_prim_q) begin
			kind_c = clm_pkg::NK_NONE;
		end
		// write the lock entry back only in the execute cycle
		if (state_q != clm_pkg::S_EXEC) begin
			lk_wr = 1'b0;
		end
	end

	always_comb begin
		rp.rd_en   = 1'b0;
		rp.rd_addr = {req.lock_index, req.client};
		rp.wr_en   = 1'b0;
		rp.wr_addr = {item_q.lock_index, item_q.client};
		rp.wr_data = rec_n;
		state_n    = state_q;
		load_out   = 1'b0;
		case (state_q)
			clm_pkg::S_IDLE: begin
				rp.rd_en = accept;
				if (accept) begin
					state_n = clm_pkg::S_EXEC;
				end
			end
			clm_pkg::S_EXEC: begin
				rp.wr_en = rec_wr;
				state_n  = (kind_c == clm_pkg::NK_NONE) ? clm_pkg::S_FIN : clm_pkg::S_NREQ;
			end
			clm_pkg::S_NREQ: begin
				rp.rd_en   = 1'b1;
				rp.rd_addr = {item_q.lock_index, who_q};
				state_n    = clm_pkg::S_NDATA;
			end
			clm_pkg::S_NDATA, clm_pkg::S_FIN: begin
				if (out_free) begin
					load_out = 1'b1;
					state_n  = clm_pkg::S_IDLE;
				end
			end
			default: state_n = clm_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= clm_pkg::S_IDLE;
			is_prim_q <= 1'b1;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cfg_we) begin
				is_prim_q <= cfg_wdata;
			end
			if (load_out) begin
				out_vld_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= req;
		end
		if (state_q == clm_pkg::S_EXEC) begin
			st_q   <= st_c;
			kind_q <= kind_c;
			who_q  <= who_c;
		end
		if (load_out) begin
			out_q.status <= st_q;
			if (state_q == clm_pkg::S_NDATA) begin
				out_q.notice_kind       <= kind_q;
				out_q.notice_client     <= who_q;
				out_q.notice_lock       <= item_q.lock_index;
				out_q.notice_request_id <= rec_rd.req_id;
			end else begin
				out_q.notice_kind       <= clm_pkg::NK_NONE;
				out_q.notice_client     <= '0;
				out_q.notice_lock       <= '0;
				out_q.notice_request_id <= '0;
			end
		end
	end

	assign rsp_valid = out_vld_q;
	assign rsp       = out_q;

	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == clm_pkg::S_EXEC)
		else $error("accepted item did not enter execution");

	a_no_accept_clear: assert property (@(posedge clk) disable iff (!arst_n)
		rec_busy |-> !accept)
		else $error("item accepted during record clearing");

	a_notice_primary: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == clm_pkg::S_EXEC && kind_c != clm_pkg::NK_NONE) |-> is_prim_q)
		else $error("notice raised while not primary");

	a_load_drains: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |=> rsp_valid && state_q == clm_pkg::S_IDLE)
		else $error("result load did not present an item");

endmodule
